// ----- rtl/lnrw_pkg.sv -----
// ----------------------------------------------------------------------------
// lnrw_pkg
// shared types and constants of the lcd nibble row writer
// ----------------------------------------------------------------------------
package lnrw_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [7:0] LCD_EN_BIT   = 8'h80;
	localparam logic [7:0] LCD_DATA_SEL = 8'h40;
	localparam logic [3:0] NIBBLE_MASK  = 4'hF;
	localparam logic [3:0] ASCII_ZERO_HI = 4'h3;
	localparam logic [7:0] CHAR_H       = 8'h48;
	localparam logic [7:0] CHAR_Z       = 8'h7A;
	localparam logic [7:0] OHM_CHAR     = 8'hF4;
	localparam logic [7:0] CURSOR_ROW0  = 8'h82;
	localparam logic [7:0] CURSOR_ROW1  = 8'hC2;

	localparam logic [0:0] OP_ROW = 1'b0;
	localparam logic [0:0] OP_RAW = 1'b1;

	// one lcd byte queued for serializing
	typedef struct packed {
		logic       sel;
		logic [7:0] code;
		logic       last;
	} lcd_byte_t;

	// queue status seen by either side
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- rtl/lcd_nibble_row_writer_unit.sv -----
// ----------------------------------------------------------------------------
// lcd_nibble_row_writer_unit
// lcd requests to 74hc595 shift-register bytes, hd44780 4-bit mode
// ----------------------------------------------------------------------------
// an item is taken on a clock edge with start high and busy low. op 0 shows
// the low four decimal digits of value on a row, op 1 sends one raw byte.
// every lcd byte leaves as six shift bytes (disable, enable, disable for the
// high then the low nibble), one per cycle, each on shift_byte for a single
// cycle while strobe is high; last marks the final byte of an item.
// items give 42 bytes (row 0), 36 bytes (row 1) or 6 bytes (raw).
// the front holds busy from accept until the last byte of the item is pushed:
// a raw item goes straight to its push, a row update first runs the bcd
// conversion, then pushes that stall on the four-entry queue while the back
// drains it; bytes still queued lengthen the busy time.
// back to back, raw items are paced by the back and row updates by the front
// (accept, conversion, queue stalls).
// the receiver cannot stall; strobe is never held off.
// reset clears the queue and both control paths; no item is in flight after.
// ----------------------------------------------------------------------------
module lcd_nibble_row_writer_unit
	import lnrw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic        row,
	input  logic [31:0] value,
	input  logic        is_data,
	input  logic [7:0]  code_byte,
	output logic        strobe,
	output logic [7:0]  shift_byte,
	output logic        last
);

	q_status_t q_status;
	lcd_byte_t push_data;
	lcd_byte_t q_data;
	logic      push;
	logic      pop;

	lnrw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (op),
		.row       (row),
		.value     (value),
		.is_data   (is_data),
		.code_byte (code_byte),
		.busy      (busy),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	lnrw_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (q_data),
		.status (q_status)
	);

	lnrw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.q_data     (q_data),
		.pop        (pop),
		.strobe     (strobe),
		.shift_byte (shift_byte),
		.last       (last)
	);

endmodule

// ----- rtl/lnrw_fifo.sv -----
// ----------------------------------------------------------------------------
// lnrw_fifo
// small register queue of lcd bytes between front and back
// ----------------------------------------------------------------------------
module lnrw_fifo
	import lnrw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lcd_byte_t wdata,
	input  logic      pop,
	output lcd_byte_t rdata,
	output q_status_t status
);

	lcd_byte_t       mem_q [QDEPTH];
	logic [QAW-1:0]  wptr_q;
	logic [QAW-1:0]  rptr_q;
	logic [QAW:0]    count_q;
	logic            do_push;
	logic            do_pop;

	assign status.full  = (count_q == (QAW+1)'(QDEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/lnrw_front.sv -----
// ----------------------------------------------------------------------------
// lnrw_front
// accepts requests, converts the row value to bcd, queues the lcd bytes
// ----------------------------------------------------------------------------
module lnrw_front
	import lnrw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        op,
	input  logic        row,
	input  logic [31:0] value,
	input  logic        is_data,
	input  logic [7:0]  code_byte,
	output logic        busy,
	input  q_status_t   q_status,
	output logic        push,
	output lcd_byte_t   push_data
);

	typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} state_t;

	state_t      state_q;
	logic        op_q;
	logic        row_q;
	logic        is_data_q;
	logic [7:0]  code_q;
	logic [31:0] val_q;
	logic [15:0] bcd_q;
	logic [4:0]  cnt_q;
	logic [2:0]  idx_q;
	logic [15:0] bcd_adj;
	logic        accept;

	// add-3 correction per digit, carry out of the top digit dropped (mod 10000)
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ?
				bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
		end
	end

	always_comb begin
		push_data.sel = 1'b1;
		unique case (idx_q)
			3'd0: begin
				push_data.code = (op_q == OP_RAW) ? code_q :
					(row_q ? CURSOR_ROW1 : CURSOR_ROW0);
				push_data.sel  = (op_q == OP_RAW) ? is_data_q : 1'b0;
			end
			3'd1:    push_data.code = {ASCII_ZERO_HI, bcd_q[15:12]};
			3'd2:    push_data.code = {ASCII_ZERO_HI, bcd_q[11:8]};
			3'd3:    push_data.code = {ASCII_ZERO_HI, bcd_q[7:4]};
			3'd4:    push_data.code = {ASCII_ZERO_HI, bcd_q[3:0]};
			3'd5:    push_data.code = row_q ? OHM_CHAR : CHAR_H;
			default: push_data.code = CHAR_Z;
		endcase
		if (op_q == OP_RAW) begin
			push_data.last = (idx_q == 3'd0);
		end else begin
			push_data.last = row_q ? (idx_q == 3'd5) : (idx_q == 3'd6);
		end
	end

	assign busy   = (state_q != F_IDLE);
	assign accept = start && !busy;
	assign push   = (state_q == F_PUSH) && !q_status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			op_q      <= 1'b0;
			row_q     <= 1'b0;
			is_data_q <= 1'b0;
			code_q    <= '0;
			val_q     <= '0;
			bcd_q     <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						op_q      <= op;
						row_q     <= row;
						is_data_q <= is_data;
						code_q    <= code_byte;
						val_q     <= value;
						bcd_q     <= '0;
						cnt_q     <= '0;
						idx_q     <= '0;
						state_q   <= (op == OP_RAW) ? F_PUSH : F_CONV;
					end
				end
				F_CONV: begin
					bcd_q <= {bcd_adj[14:0], val_q[31]};
					val_q <= {val_q[30:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push) begin
						idx_q <= idx_q + 1'b1;
						if (push_data.last) begin
							state_q <= F_IDLE;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/lnrw_back.sv -----
// ----------------------------------------------------------------------------
// lnrw_back
// splits each queued lcd byte into six shift-register bytes
// ----------------------------------------------------------------------------
module lnrw_back
	import lnrw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  q_status_t  q_status,
	input  lcd_byte_t  q_data,
	output logic       pop,
	output logic       strobe,
	output logic [7:0] shift_byte,
	output logic       last
);

	lcd_byte_t  cur_q;
	logic [2:0] step_q;
	logic       active_q;
	logic       step_end;
	logic [3:0] nib;
	logic       en;

	assign step_end = active_q && (step_q == 3'd5);
	assign pop      = (!active_q || step_end) && !q_status.empty;
	assign nib      = (step_q < 3'd3) ? (cur_q.code[7:4] & NIBBLE_MASK)
	                                  : (cur_q.code[3:0] & NIBBLE_MASK);
	assign en       = (step_q == 3'd1) || (step_q == 3'd4);

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= '0;
			active_q   <= 1'b0;
			strobe     <= 1'b0;
			shift_byte <= '0;
			last       <= 1'b0;
		end else begin
			strobe     <= active_q;
			shift_byte <= (en ? LCD_EN_BIT : 8'h00) | (cur_q.sel ? LCD_DATA_SEL : 8'h00)
			              | {4'h0, nib};
			last       <= step_end && cur_q.last;
			if (pop) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (step_end) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

// ----- rtl/lnrw_checker.sv -----
// ----------------------------------------------------------------------------
// lnrw_checker
// port-level checks of the lcd nibble row writer
// ----------------------------------------------------------------------------
module lnrw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [7:0] shift_byte,
	input logic       last
);

	// an accepted item keeps the front busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after item");

	a_last_with_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last without strobe");

	// enable pulse is framed by disable bytes
	a_en_followed: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && shift_byte[7] |=> strobe && !shift_byte[7])
		else $error("enable byte not followed by disable byte");

	a_en_preceded: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && shift_byte[7] |-> $past(strobe) && !$past(shift_byte[7]))
		else $error("enable byte not preceded by disable byte");

	a_last_no_en: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !shift_byte[7])
		else $error("last byte carries enable");

endmodule

bind lcd_nibble_row_writer_unit lnrw_checker u_lnrw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.strobe     (strobe),
	.shift_byte (shift_byte),
	.last       (last)
);
